/* hw/rtl/gce_pkg.sv */
// Shared types and constants for the grid corridor expander.
// No dependencies.
package gce_pkg;
    localparam int GRID_COLS_DEF = 256;
    localparam int GRID_ROWS_DEF = 256;
    localparam logic [7:0] COST_LETHAL = 8'd254;
    localparam logic [7:0] COST_INSCRIBED = 8'd253;
    localparam int NUM_SIDES = 4;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [2:0] REG_MAP_WIDTH = 3'd0;
    localparam logic [2:0] REG_MAP_HEIGHT = 3'd1;
    localparam logic [2:0] REG_SAFETY = 3'd2;
    localparam logic [2:0] REG_MAX_ITER = 3'd3;
    localparam logic [2:0] REG_INIT_STEP = 3'd4;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_OUTSIDE = 2'd1;
    localparam logic [1:0] ST_NO_START = 2'd2;
    localparam logic [1:0] ST_ITER_LIMIT = 2'd3;

    // Datapath commands from the controller.
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,       // latch query, set center = query
        CMD_AREA_INIT,  // set area scan to square around center (+extra)
        CMD_AREA_STEP,  // advance area scan
        CMD_CAND_NEXT,  // compute next start candidate from counter
        CMD_EXP_INIT,   // clear reaches, counter = 4 (+extra: take candidate as start)
        CMD_EXP_SIDE,   // set reach of side, begin edge scan
        CMD_EDGE_STEP,  // advance edge scan
        CMD_CNT_INC     // counter++
    } cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic extra;     // candidate square reaches one cell further on its high x and y sides
        logic [1:0] side;
    } ctl_t;

    typedef struct packed {
        logic scan_hit;  // current read cell blocked (valid when scan_vld)
        logic scan_vld;
        logic scan_last; // current cell is the last one of the scan
        logic scan_empty;
        logic cnt_lim;   // counter >= max step count
        logic cand_ok;   // candidate inside map
        logic ring_safe; // ring >= safety_cells
        logic outside;
        logic [1:0] side;
    } sts_t;
endpackage

/* hw/rtl/grid_corridor_expander_core.sv */
// Top level of the grid corridor expander: controller plus datapath.
// Depends on gce_pkg, gce_ctrl, gce_datapath.
//
//  channel | signals                                   | direction
//  in      | in_valid/in_ready, op, cell_x, cell_y, cost | into block
//  out     | out_valid/out_ready, status, start_x..ext_up | out of block
//  cfg     | cfg_we, cfg_idx, cfg_data                  | into block
//
// A query reads the grid through one memory port with a registered read,
// scanning the clearance squares and edges, and then steps through the
// expansion sides and start candidates.
// After reset a clearing pass over all GRID_COLS*GRID_ROWS cells zeroes the grid;
// in_ready stays low during it. The result is held until out_ready.
module grid_corridor_expander_core
    import gce_pkg::*;
#(
    parameter int GRID_COLS = GRID_COLS_DEF,
    parameter int GRID_ROWS = GRID_ROWS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_idx,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [7:0]  cell_x,
    input  logic [7:0]  cell_y,
    input  logic [7:0]  cost,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [7:0]  start_x,
    output logic [7:0]  start_y,
    output logic [7:0]  ext_left,
    output logic [7:0]  ext_down,
    output logic [7:0]  ext_right,
    output logic [7:0]  ext_up
);
    ctl_t ctl;
    sts_t sts;
    logic [7:0] sx, sy;
    logic [7:0] reach [NUM_SIDES];
    logic zext, zst, clearing;

    // clearing comes from the datapath's sweep counter and holds ready low
    gce_datapath #(.GRID_COLS(GRID_COLS), .GRID_ROWS(GRID_ROWS)) u_dp (
        .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_data,
        .wr_en(in_valid && in_ready && op == OP_WRITE),
        .in_x(cell_x), .in_y(cell_y), .in_cost(cost),
        .ctl, .sts, .clearing, .sx, .sy, .reach
    );

    logic rdy_raw;
    gce_ctrl u_ctrl (
        .clk, .rst_n, .in_valid, .in_ready(rdy_raw), .in_op(op),
        .out_valid, .out_ready, .sts, .clearing,
        .ctl, .status, .zero_ext(zext), .zero_start(zst)
    );
    assign in_ready = rdy_raw;

    assign start_x = zst ? 8'd0 : sx;
    assign start_y = zst ? 8'd0 : sy;
    assign ext_left = zext ? 8'd0 : reach[0];
    assign ext_down = zext ? 8'd0 : reach[1];
    assign ext_right = zext ? 8'd0 : reach[2];
    assign ext_up = zext ? 8'd0 : reach[3];
endmodule

/* hw/rtl/gce_datapath.sv */
// Datapath: occupancy memory, scan address generators, counters, extents.
// Depends on gce_pkg.
module gce_datapath
    import gce_pkg::*;
#(
    parameter int GRID_COLS = GRID_COLS_DEF,
    parameter int GRID_ROWS = GRID_ROWS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_idx,
    input  logic [15:0] cfg_data,
    input  logic        wr_en,
    input  logic [7:0]  in_x,
    input  logic [7:0]  in_y,
    input  logic [7:0]  in_cost,
    input  ctl_t        ctl,
    output sts_t        sts,
    output logic        clearing,
    output logic [7:0]  sx,
    output logic [7:0]  sy,
    output logic [7:0]  reach [NUM_SIDES]
);
    localparam int XW = $clog2(GRID_COLS);
    localparam int YW = $clog2(GRID_ROWS);
    localparam int DEPTH = GRID_COLS * GRID_ROWS;
    // signed coordinate width: query +/- ring (up to 16383) plus clearance
    localparam int CW = 18;
    localparam int CLRW = $clog2(DEPTH);

    logic [8:0] map_w_reg, map_h_reg;
    logic [7:0] safety_reg;
    logic [15:0] max_iter_reg;
    logic [5:0] init_step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_w_reg <= 9'd256;
            map_h_reg <= 9'd256;
            safety_reg <= 8'd10;
            max_iter_reg <= 16'd1000;
            init_step_reg <= 6'd2;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_MAP_WIDTH:  map_w_reg <= cfg_data[8:0];
                REG_MAP_HEIGHT: map_h_reg <= cfg_data[8:0];
                REG_SAFETY:     safety_reg <= cfg_data[7:0];
                REG_MAX_ITER:   max_iter_reg <= cfg_data;
                REG_INIT_STEP:  init_step_reg <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // effective map size
    logic signed [CW-1:0] eff_w, eff_h;
    always_comb
    begin
        eff_w = ($unsigned(CW'(map_w_reg)) < CW'(GRID_COLS)) ? CW'(map_w_reg) : CW'(GRID_COLS);
        eff_h = ($unsigned(CW'(map_h_reg)) < CW'(GRID_ROWS)) ? CW'(map_h_reg) : CW'(GRID_ROWS);
    end

    // occupancy memory; valid on the first clear pass is covered by the
    // datapath's own clearing sweep, which writes zeros through this port.
    logic mem [DEPTH];
    logic mem_q_reg;
    logic [CLRW-1:0] rd_addr;

    logic wr_ok;
    logic [CLRW-1:0] wr_addr;
    logic wr_bit;
    assign wr_ok = (32'(in_x) < GRID_COLS) && (32'(in_y) < GRID_ROWS);
    assign wr_addr = CLRW'(YW'(in_y)) * CLRW'(GRID_COLS) + CLRW'(XW'(in_x));
    assign wr_bit = (in_cost == COST_LETHAL) || (in_cost == COST_INSCRIBED);

    // clearing sweep after reset
    logic [CLRW:0] clr_cnt_reg;
    assign clearing = !clr_cnt_reg[CLRW];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else if (clearing)
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (clearing)
            mem[clr_cnt_reg[CLRW-1:0]] <= 1'b0;
        else if (wr_en && wr_ok)
            mem[wr_addr] <= wr_bit;
        mem_q_reg <= mem[rd_addr];
    end

    // query / center / counter
    logic [7:0] qx_reg, qy_reg, sx_reg, sy_reg;
    logic signed [CW-1:0] px_reg, py_reg;
    logic [15:0] cnt_reg;
    logic [7:0] reach_reg [NUM_SIDES];
    logic [13:0] ring;
    assign ring = cnt_reg[15:2];

    // scan rectangle
    logic signed [CW-1:0] x0_reg, x1_reg, y0_reg, y1_reg, cx_reg, cy_reg;
    logic cell_in;
    logic rd_pend_reg;   // a read was issued last cycle
    logic rd_in_reg;     // that read was inside map
    logic last_pend_reg;
    logic empty_reg;

    logic signed [CW-1:0] scx, scy, sr0, sr1, sr2, sr3;
    assign scx = CW'(sx_reg);
    assign scy = CW'(sy_reg);
    assign sr0 = CW'(reach_reg[0]);
    assign sr1 = CW'(reach_reg[1]);
    assign sr2 = CW'(reach_reg[2]);
    assign sr3 = CW'(reach_reg[3]);

    assign cell_in = (cx_reg >= 0) && (cy_reg >= 0) && (cx_reg < eff_w) && (cy_reg < eff_h);
    assign rd_addr = CLRW'(cy_reg[YW-1:0]) * CLRW'(GRID_COLS) + CLRW'(cx_reg[XW-1:0]);

    logic at_last;
    assign at_last = (cx_reg == x1_reg) && (cy_reg == y1_reg);

    logic signed [CW-1:0] st, nx, ny;
    always_comb
    begin
        st = CW'(init_step_reg);
        nx = (ctl.extra) ? px_reg : CW'(qx_reg);
        ny = (ctl.extra) ? py_reg : CW'(qy_reg);
    end

    always_ff @(posedge clk)
    begin
        rd_pend_reg <= 1'b0;
        last_pend_reg <= 1'b0;
        unique case (ctl.cmd)
            CMD_LOAD:
            begin
                qx_reg <= in_x;
                qy_reg <= in_y;
                sx_reg <= in_x;
                sy_reg <= in_y;
                cnt_reg <= 16'd4;
            end
            CMD_AREA_INIT:
            begin
                // clipped square, scanned column by column with y stepping fastest
                x0_reg <= (nx - st < 0) ? '0 : nx - st;
                y0_reg <= (ny - st < 0) ? '0 : ny - st;
                x1_reg <= (nx + st + CW'(ctl.extra) > eff_w - 1) ? eff_w - 1
                          : nx + st + CW'(ctl.extra);
                y1_reg <= (ny + st + CW'(ctl.extra) > eff_h - 1) ? eff_h - 1
                          : ny + st + CW'(ctl.extra);
                cx_reg <= (nx - st < 0) ? '0 : nx - st;
                cy_reg <= (ny - st < 0) ? '0 : ny - st;
                empty_reg <= 1'b0;
            end
            CMD_AREA_STEP, CMD_EDGE_STEP:
            begin
                rd_pend_reg <= 1'b1;
                rd_in_reg <= cell_in;
                last_pend_reg <= at_last;
                if (cy_reg == y1_reg)
                begin
                    cy_reg <= y0_reg;
                    cx_reg <= cx_reg + 1'b1;
                end
                else
                    cy_reg <= cy_reg + 1'b1;
            end
            CMD_CAND_NEXT:
            begin
                unique case (cnt_reg[1:0])
                    2'd0:
                    begin
                        px_reg <= CW'(qx_reg) - CW'(ring);
                        py_reg <= CW'(qy_reg);
                    end
                    2'd1:
                    begin
                        px_reg <= CW'(qx_reg);
                        py_reg <= CW'(qy_reg) - CW'(ring);
                    end
                    2'd2:
                    begin
                        px_reg <= CW'(qx_reg) + CW'(ring);
                        py_reg <= CW'(qy_reg);
                    end
                    default:
                    begin
                        px_reg <= CW'(qx_reg);
                        py_reg <= CW'(qy_reg) + CW'(ring);
                    end
                endcase
            end
            CMD_EXP_INIT:
            begin
                cnt_reg <= 16'd4;
                for (int i = 0; i < NUM_SIDES; i++)
                    reach_reg[i] <= '0;
                // shifted start: the candidate that passed becomes the center
                if (ctl.extra)
                begin
                    sx_reg <= px_reg[7:0];
                    sy_reg <= py_reg[7:0];
                end
            end
            CMD_EXP_SIDE:
            begin
                reach_reg[ctl.side] <= ring[7:0];
                cnt_reg <= cnt_reg + 1'b1;
                unique case (ctl.side)
                    2'd0:
                    begin
                        x0_reg <= scx - CW'(ring); x1_reg <= scx - CW'(ring);
                        cx_reg <= scx - CW'(ring);
                        y0_reg <= scy - sr1; y1_reg <= scy + sr3; cy_reg <= scy - sr1;
                    end
                    2'd2:
                    begin
                        x0_reg <= scx + CW'(ring); x1_reg <= scx + CW'(ring);
                        cx_reg <= scx + CW'(ring);
                        y0_reg <= scy - sr1; y1_reg <= scy + sr3; cy_reg <= scy - sr1;
                    end
                    2'd1:
                    begin
                        y0_reg <= scy - CW'(ring); y1_reg <= scy - CW'(ring);
                        cy_reg <= scy - CW'(ring);
                        x0_reg <= scx - sr0; x1_reg <= scx + sr2; cx_reg <= scx - sr0;
                    end
                    default:
                    begin
                        y0_reg <= scy + CW'(ring); y1_reg <= scy + CW'(ring);
                        cy_reg <= scy + CW'(ring);
                        x0_reg <= scx - sr0; x1_reg <= scx + sr2; cx_reg <= scx - sr0;
                    end
                endcase
            end
            CMD_CNT_INC: cnt_reg <= cnt_reg + 1'b1;
            default: ;
        endcase
    end

    always_comb
    begin
        sts.scan_vld = rd_pend_reg;
        // outside-map cells count as blocked
        sts.scan_hit = !rd_in_reg || mem_q_reg;
        sts.scan_last = last_pend_reg;
        sts.scan_empty = (x0_reg > x1_reg) || (y0_reg > y1_reg) || empty_reg;
        sts.cnt_lim = (cnt_reg >= max_iter_reg);
        sts.cand_ok = (px_reg >= 0) && (py_reg >= 0) && (px_reg < eff_w) && (py_reg < eff_h);
        sts.ring_safe = ({2'b0, ring} >= 16'(safety_reg));
        sts.outside = (CW'(in_x) >= eff_w) || (CW'(in_y) >= eff_h) || clearing;
        sts.side = cnt_reg[1:0];
    end

    assign sx = sx_reg;
    assign sy = sy_reg;
    assign reach = reach_reg;
endmodule

/* hw/rtl/gce_ctrl.sv */
// Controller state machine sequencing start search and edge expansion.
// Depends on gce_pkg.
module gce_ctrl
    import gce_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       in_op,
    output logic       out_valid,
    input  logic       out_ready,
    input  sts_t       sts,
    input  logic       clearing,
    output ctl_t       ctl,
    output logic [1:0] status,
    output logic       zero_ext,
    output logic       zero_start
);
    typedef enum logic [3:0] {
        S_IDLE, S_AREA0, S_AREA, S_CAND, S_CAND_CHK, S_CAREA0, S_CAREA,
        S_EXP, S_EDGE0, S_EDGE, S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic [1:0] status_reg, status_next;
    logic zext_reg, zext_next, zst_reg, zst_next;
    logic [3:0] stop_reg, stop_next;
    logic [1:0] side_reg, side_next;

    assign in_ready = (state_reg == S_IDLE) && !clearing;
    assign out_valid = (state_reg == S_DONE);
    assign status = status_reg;
    assign zero_ext = zext_reg;
    assign zero_start = zst_reg;

    always_comb
    begin
        state_next = state_reg;
        status_next = status_reg;
        zext_next = zext_reg;
        zst_next = zst_reg;
        stop_next = stop_reg;
        side_next = side_reg;
        ctl = '{cmd: CMD_NONE, extra: 1'b0, side: side_reg};
        unique case (state_reg)
            S_IDLE:
                if (in_valid && in_ready && in_op == OP_QUERY)
                begin
                    zext_next = 1'b1;
                    zst_next = 1'b0;
                    if (sts.outside)
                    begin
                        status_next = ST_OUTSIDE;
                        zst_next = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ctl.cmd = CMD_LOAD;
                        state_next = S_AREA0;
                    end
                end
            S_AREA0:
            begin
                ctl.cmd = CMD_AREA_INIT;
                state_next = S_AREA;
            end
            S_AREA:
            begin
                if (sts.scan_vld && sts.scan_hit)
                    state_next = S_CAND;
                else if (sts.scan_vld && sts.scan_last)
                    state_next = S_EXP;
                else if (!sts.scan_vld || !sts.scan_last)
                    ctl.cmd = sts.scan_vld ? CMD_AREA_STEP
                              : (sts.scan_empty ? CMD_NONE : CMD_AREA_STEP);
                if (!sts.scan_vld && sts.scan_empty)
                    state_next = S_EXP;
                // only issue when no read outstanding
                if (sts.scan_vld == 1'b0 && !sts.scan_empty)
                    ctl.cmd = CMD_AREA_STEP;
                else
                    ctl.cmd = CMD_NONE;
            end
            S_CAND:
                if (sts.cnt_lim)
                begin
                    status_next = ST_NO_START;
                    state_next = S_DONE;
                end
                else
                begin
                    ctl.cmd = CMD_CAND_NEXT;
                    state_next = S_CAND_CHK;
                end
            S_CAND_CHK:
                if (sts.cand_ok)
                begin
                    ctl.cmd = CMD_AREA_INIT;
                    ctl.extra = 1'b1;
                    state_next = S_CAREA;
                end
                else
                begin
                    ctl.cmd = CMD_CNT_INC;
                    state_next = S_CAND;
                end
            S_CAREA0: state_next = S_CAREA;
            S_CAREA:
            begin
                if (sts.scan_vld && sts.scan_hit)
                begin
                    ctl.cmd = CMD_CNT_INC;
                    state_next = S_CAND;
                end
                else if ((sts.scan_vld && sts.scan_last) || (!sts.scan_vld && sts.scan_empty))
                    state_next = S_EXP;
                else if (!sts.scan_vld)
                    ctl.cmd = CMD_AREA_STEP;
            end
            S_EXP:
            begin
                // first entry arrives with stop_reg cleared by S_AREA or S_CAREA exits
                if (stop_reg == 4'hF || sts.cnt_lim)
                begin
                    status_next = sts.cnt_lim ? ST_ITER_LIMIT : ST_OK;
                    zext_next = sts.cnt_lim;
                    state_next = S_DONE;
                end
                else if (stop_reg[sts.side])
                    ctl.cmd = CMD_CNT_INC;
                else
                begin
                    ctl.cmd = CMD_EXP_SIDE;
                    ctl.side = sts.side;
                    side_next = sts.side;
                    if (sts.ring_safe)
                        stop_next[sts.side] = 1'b1;
                    else
                        state_next = S_EDGE0;
                end
            end
            S_EDGE0:
            begin
                ctl.cmd = CMD_EDGE_STEP;
                state_next = S_EDGE;
            end
            S_EDGE:
            begin
                if (sts.scan_vld && sts.scan_hit)
                begin
                    stop_next[side_reg] = 1'b1;
                    state_next = S_EXP;
                end
                else if (sts.scan_vld && sts.scan_last)
                    state_next = S_EXP;
                else if (!sts.scan_vld)
                    ctl.cmd = CMD_EDGE_STEP;
            end
            S_DONE:
                if (out_ready)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
        // entering expansion from the start search resets the expansion state;
        // a passing candidate square also moves the start to that candidate
        if ((state_reg == S_AREA || state_reg == S_CAREA) && state_next == S_EXP)
        begin
            ctl.cmd = CMD_EXP_INIT;
            ctl.extra = (state_reg == S_CAREA);
            stop_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            status_reg <= ST_OK;
            zext_reg <= 1'b1;
            zst_reg <= 1'b0;
            stop_reg <= '0;
            side_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            status_reg <= status_next;
            zext_reg <= zext_next;
            zst_reg <= zst_next;
            stop_reg <= stop_next;
            side_reg <= side_next;
        end
    end
endmodule

/* hw/rtl/gce_checker.sv */
// Port-level checker for grid_corridor_expander_core, bound to the top.
// Depends on gce_pkg.
module gce_checker
    import gce_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic op,
    input logic out_valid,
    input logic out_ready,
    input logic [1:0] status,
    input logic [7:0] ext_left
);
    // no new input taken while a result waits
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken while result pending");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status))
        else $error("result dropped");
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> ext_left == 8'd0)
        else $error("extent on failed query");
    a_write_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && op == OP_WRITE |=> !out_valid)
        else $error("write produced a result");
endmodule

bind grid_corridor_expander_core gce_checker u_chk (
    .clk, .rst_n, .in_valid, .in_ready, .op, .out_valid, .out_ready,
    .status, .ext_left
);
